[design/spg_pkg.sv]
`timescale 1ns / 1ps

package spg_pkg;

  // sponge geometry
  localparam int unsigned StateBits  = 272;
  localparam int unsigned StateBytes = StateBits / 8;
  localparam int unsigned PermMul    = StateBits / 4;
  localparam int unsigned PermMod    = StateBits - 1;

  // round counter schedule and padding
  localparam logic [7:0] LfsrStart = 8'h9e;
  localparam logic [7:0] LfsrStop  = 8'hff;
  localparam logic [7:0] PadByte   = 8'h80;

  // 4-bit s-box
  localparam logic [3:0] Sbox [16] = '{
    4'he, 4'hd, 4'hb, 4'h0, 4'h2, 4'h1, 4'h4, 4'hf,
    4'h7, 4'ha, 4'h8, 4'h5, 4'h9, 4'hc, 4'h3, 4'h6
  };

  typedef logic [StateBits-1:0] state_t;

  // input item
  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [1:0] byte_count;
    logic       last_block;
  } in_t;

  // result item
  typedef struct packed {
    logic [7:0] digest_first;
    logic [7:0] digest_second;
    logic [3:0] word_index;
    logic       last_word;
  } out_t;

  typedef enum logic [1:0] {
    StIdle,
    StPerm,
    StOut
  } fsm_e;

  // round counter step
  function automatic logic [7:0] lfsr_next(input logic [7:0] v);
    logic fb;
    fb = v[1] ^ v[2] ^ v[3] ^ v[7];
    return {v[6:0], fb};
  endfunction

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

endpackage

[design/spg_round.sv]
`timescale 1ns / 1ps

module spg_round import spg_pkg::*; (
  input  state_t     state_i,
  input  logic [7:0] ctr_i,
  output state_t     state_o
);

  state_t with_ctr;
  state_t subst;
  state_t perm;

  // round counter into the lowest and highest byte
  always_comb begin
    with_ctr = state_i;
    with_ctr[7:0] = state_i[7:0] ^ ctr_i;
    with_ctr[StateBits-1 -: 8] = state_i[StateBits-1 -: 8] ^ bit_rev8(ctr_i);
  end

  // s-box layer on every nibble
  always_comb begin
    for (int n = 0; n < StateBits / 4; n++) begin
      subst[4*n +: 4] = Sbox[with_ctr[4*n +: 4]];
    end
  end

  // bit permutation: bit j moves to j*68 mod 271, top bit stays
  always_comb begin
    perm = '0;
    for (int j = 0; j < StateBits - 1; j++) begin
      perm[(j * PermMul) % PermMod] = subst[j];
    end
    perm[StateBits-1] = subst[StateBits-1];
  end

  assign state_o = perm;

endmodule

[design/spongent_sponge_hash.sv]
`timescale 1ns / 1ps

// Sponge hash, 272-bit state, 16-bit rate, 256-bit capacity.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries two message
// bytes per transfer; last_block ends the message and byte_count (0..2,
// three counts as two) then gives the valid bytes, padding is added internally.
// Output channel (out_valid_o / out_stall_i / out_data_o) carries the
// digest as 16-bit words with word_index and last_word, only after a last
// block.
// Timing: the permutation runs one round per cycle on a single round unit,
// 140 rounds, sequenced by the round-counter lfsr.
//   non-last block : one permutation from transfer until the next input is taken
//   last block     : one permutation, or two (two bytes need an extra padding
//                    block) until the first word, then one permutation between
//                    words once each word is taken
// The block takes no input while a message block or digest is in work.
// A stalled word simply holds; the state is frozen until it is taken.
// After the final word the sponge state is cleared for the next message.
// Reset clears the state and returns the block to idle.
module spongent_sponge_hash import spg_pkg::*; #(
  parameter int unsigned DIGEST_BITS = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned WordsRaw = (DIGEST_BITS + 15) / 16;
  localparam int unsigned NumWords = (WordsRaw < 1) ? 1 : ((WordsRaw > 16) ? 16 : WordsRaw);
  localparam logic [3:0]  LastIdx  = 4'(NumWords - 1);

  fsm_e       fsm_q, fsm_d;
  state_t     state_q, state_d;
  logic [7:0] ctr_q, ctr_d;
  logic       pad_q, pad_d;
  logic       squeeze_q, squeeze_d;
  logic [3:0] word_q, word_d;

  state_t     rnd_state;
  logic [7:0] ctr_nxt;
  logic       in_xfer;
  logic       out_xfer;
  logic       perm_done;

  // shared round unit
  spg_round u_round (
    .state_i (state_q),
    .ctr_i   (ctr_q),
    .state_o (rnd_state)
  );

  assign ctr_nxt   = lfsr_next(ctr_q);
  assign perm_done = (ctr_nxt == LfsrStop);
  assign in_xfer   = in_valid_i && (fsm_q == StIdle);
  assign out_xfer  = (fsm_q == StOut) && !out_stall_i;

  // next state
  always_comb begin
    fsm_d = fsm_q;
    unique case (fsm_q)
      StIdle: begin
        if (in_xfer) fsm_d = StPerm;
      end
      StPerm: begin
        if (perm_done && !pad_q) begin
          fsm_d = squeeze_q ? StOut : StIdle;
        end
      end
      StOut: begin
        if (out_xfer) fsm_d = (word_q == LastIdx) ? StIdle : StPerm;
      end
      default: fsm_d = StIdle;
    endcase
  end

  // datapath next values
  always_comb begin
    state_d   = state_q;
    ctr_d     = ctr_q;
    pad_d     = pad_q;
    squeeze_d = squeeze_q;
    word_d    = word_q;
    unique case (fsm_q)
      StIdle: begin
        if (in_xfer) begin
          ctr_d  = LfsrStart;
          word_d = '0;
          if (!in_data_i.last_block) begin
            state_d[7:0]  = state_q[7:0] ^ in_data_i.byte_first;
            state_d[15:8] = state_q[15:8] ^ in_data_i.byte_second;
            pad_d         = 1'b0;
            squeeze_d     = 1'b0;
          end else begin
            squeeze_d = 1'b1;
            case (in_data_i.byte_count) inside
              2'd2, 2'd3: begin
                state_d[7:0]  = state_q[7:0] ^ in_data_i.byte_first;
                state_d[15:8] = state_q[15:8] ^ in_data_i.byte_second;
                pad_d         = 1'b1;
              end
              2'd1: begin
                state_d[7:0]  = state_q[7:0] ^ in_data_i.byte_first;
                state_d[15:8] = state_q[15:8] ^ PadByte;
                pad_d         = 1'b0;
              end
              default: begin
                state_d[7:0] = state_q[7:0] ^ PadByte;
                pad_d        = 1'b0;
              end
            endcase
          end
        end
      end
      StPerm: begin
        state_d = rnd_state;
        ctr_d   = ctr_nxt;
        // full message block absorbed: add the padding block and go again
        if (perm_done && pad_q) begin
          state_d[7:0] = rnd_state[7:0] ^ PadByte;
          ctr_d        = LfsrStart;
          pad_d        = 1'b0;
        end
      end
      StOut: begin
        if (out_xfer) begin
          if (word_q == LastIdx) begin
            state_d   = '0;
            squeeze_d = 1'b0;
            word_d    = '0;
          end else begin
            ctr_d  = LfsrStart;
            word_d = word_q + 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= StIdle;
      state_q   <= '0;
      ctr_q     <= LfsrStart;
      pad_q     <= 1'b0;
      squeeze_q <= 1'b0;
      word_q    <= '0;
    end else begin
      fsm_q     <= fsm_d;
      state_q   <= state_d;
      ctr_q     <= ctr_d;
      pad_q     <= pad_d;
      squeeze_q <= squeeze_d;
      word_q    <= word_d;
    end
  end

  // port outputs
  always_comb begin
    in_stall_o                = (fsm_q != StIdle);
    out_valid_o               = (fsm_q == StOut);
    out_data_o.digest_first   = state_q[7:0];
    out_data_o.digest_second  = state_q[15:8];
    out_data_o.word_index     = word_q;
    out_data_o.last_word      = (word_q == LastIdx);
  end

endmodule

[design/spg_checker.sv]
`timescale 1ns / 1ps

module spg_checker import spg_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input out_t out_data_o
);

  // a stalled word holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled digest word changed");

  // no input is taken while a digest word is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during squeeze");

  // a transfer starts a permutation, so the input closes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o && !out_valid_o)
    else $error("input not closed after transfer");

  // a permutation separates consecutive digest words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word |=> !out_valid_o)
    else $error("digest word repeated without permutation");

endmodule

bind spongent_sponge_hash spg_checker u_spg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[verif/spongent_sponge_hash_tb.sv]
`timescale 1ns / 1ps

module spongent_sponge_hash_tb;
  import spg_pkg::*;

  localparam int unsigned DigestBits  = 256;
  localparam int unsigned RandItems   = 350;
  localparam int unsigned QuietTail   = 30;
  localparam int unsigned HoldCycles  = 1500;
  localparam int unsigned HoldAtWord  = 200;
  localparam int unsigned StuckLimit  = 10000;
  localparam int unsigned DrainCycles = 300;

  localparam logic [3:0] SPG_SBOX [16] = '{
    4'he, 4'hd, 4'hb, 4'h0, 4'h2, 4'h1, 4'h4, 4'hf,
    4'h7, 4'ha, 4'h8, 4'h5, 4'h9, 4'hc, 4'h3, 4'h6
  };

  // directed messages: extremes of the bytes, every tail length, saturated count,
  // ignored count and bytes
  localparam int unsigned NumDirected = 16;
  localparam in_t DIRECTED [NumDirected] = '{
    '{8'h00, 8'h00, 2'd0, 1'b1},   // empty message right after reset
    '{8'h00, 8'h00, 2'd1, 1'b1},
    '{8'hff, 8'hff, 2'd1, 1'b1},   // second byte must be ignored
    '{8'h00, 8'h00, 2'd2, 1'b1},
    '{8'hff, 8'hff, 2'd2, 1'b1},
    '{8'ha5, 8'h5a, 2'd3, 1'b1},   // count three saturates to two
    '{8'hff, 8'hff, 2'd0, 1'b0},   // count ignored on a non-last block
    '{8'h00, 8'h00, 2'd0, 1'b1},
    '{8'h00, 8'h00, 2'd3, 1'b0},
    '{8'h12, 8'h34, 2'd1, 1'b0},
    '{8'hff, 8'h00, 2'd1, 1'b1},
    '{8'hff, 8'hff, 2'd0, 1'b1},   // both bytes ignored with count zero
    '{8'h80, 8'h01, 2'd2, 1'b0},
    '{8'h55, 8'haa, 2'd2, 1'b1},
    '{8'h01, 8'h80, 2'd3, 1'b0},
    '{8'hfe, 8'h7f, 2'd3, 1'b1}
  };

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  state_t      sponge_model = '0;
  out_t        digest_q [$];
  bit          quiet        = 1'b0;
  int unsigned n_errors     = 0;
  int unsigned n_items      = 0;
  int unsigned n_msgs       = 0;
  int unsigned n_words      = 0;
  int unsigned stuck_cycles = 0;

  spongent_sponge_hash #(
    .DIGEST_BITS(DigestBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // 140-round spongent permutation over the 272-bit state, byte i at bits 8i+7:8i
  function automatic state_t spongent_perm(state_t s);
    state_t      t;
    logic [7:0]  rc;
    logic [7:0]  rc_rev;
    int unsigned rounds;
    int unsigned d;
    int          b;
    int          n;
    int          j;
    rc     = 8'h9e;
    rounds = 0;
    do begin
      for (b = 0; b < 8; b++) rc_rev[b] = rc[7-b];
      s[7:0]     ^= rc;
      s[271:264] ^= rc_rev;
      rc = {rc[6:0], rc[1] ^ rc[2] ^ rc[3] ^ rc[7]};
      for (n = 0; n < 68; n++) s[4*n +: 4] = SPG_SBOX[s[4*n +: 4]];
      t = '0;
      for (j = 0; j < 271; j++) begin
        d = (j * 68) % 271;
        t[d] = s[j];
      end
      t[271] = s[271];
      s = t;
      rounds++;
    end while (rc != 8'hff && rounds < 256);
    return s;
  endfunction

  // absorb one transfer into the model and queue the digest words it releases
  task automatic absorb_block(input in_t it);
    int unsigned cnt;
    int unsigned words;
    int unsigned k;
    out_t        w;
    if (!it.last_block) begin
      sponge_model[7:0]  ^= it.byte_first;
      sponge_model[15:8] ^= it.byte_second;
      sponge_model = spongent_perm(sponge_model);
    end else begin
      cnt = (it.byte_count > 2) ? 2 : it.byte_count;
      if (cnt == 2) begin
        sponge_model[7:0]  ^= it.byte_first;
        sponge_model[15:8] ^= it.byte_second;
        sponge_model = spongent_perm(sponge_model);
        sponge_model[7:0] ^= 8'h80;
      end else if (cnt == 1) begin
        sponge_model[7:0]  ^= it.byte_first;
        sponge_model[15:8] ^= 8'h80;
      end else begin
        sponge_model[7:0] ^= 8'h80;
      end
      sponge_model = spongent_perm(sponge_model);
      words = (DigestBits + 15) / 16;
      if (words < 1) words = 1;
      if (words > 16) words = 16;
      for (k = 0; k < words; k++) begin
        w.digest_first  = sponge_model[7:0];
        w.digest_second = sponge_model[15:8];
        w.word_index    = 4'(k);
        w.last_word     = (k + 1 == words);
        digest_q.push_back(w);
        if (k + 1 < words) sponge_model = spongent_perm(sponge_model);
      end
      sponge_model = '0;
    end
  endtask

  // offer one item, with an occasional idle burst ahead of it
  task automatic send_item(input in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // receiver: short stall bursts, one long hold-off once the digest stream is going
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!hold_done && n_words >= HoldAtWord) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // transfer monitor: check words, predict from accepted items, watch for hangs
  always @(posedge clk_i) begin
    out_t exp_w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_words++;
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_data_o);
          n_errors++;
        end else begin
          exp_w = digest_q.pop_front();
          if (out_data_o.digest_first !== exp_w.digest_first) begin
            $error("digest_first: expected %h, got %h",
                   exp_w.digest_first, out_data_o.digest_first);
            n_errors++;
          end
          if (out_data_o.digest_second !== exp_w.digest_second) begin
            $error("digest_second: expected %h, got %h",
                   exp_w.digest_second, out_data_o.digest_second);
            n_errors++;
          end
          if (out_data_o.word_index !== exp_w.word_index) begin
            $error("word_index: expected %0d, got %0d",
                   exp_w.word_index, out_data_o.word_index);
            n_errors++;
          end
          if (out_data_o.last_word !== exp_w.last_word) begin
            $error("last_word: expected %0d, got %0d",
                   exp_w.last_word, out_data_o.last_word);
            n_errors++;
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        n_items++;
        if (in_data_i.last_block) n_msgs++;
        absorb_block(in_data_i);
      end
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= StuckLimit) begin
        $display("timeout: no transfer for %0d cycles", StuckLimit);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    in_t         it;
    int unsigned n_sent;
    int unsigned len;
    int unsigned i;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, every row checked against the predictor
    for (i = 0; i < NumDirected; i++) send_item(DIRECTED[i]);
    in_valid_i <= 1'b0;

    // sender pause until the whole digest backlog has drained
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);

    // random messages, mostly short, now and then a long one
    n_sent = 0;
    while (n_sent < RandItems) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 14) : $urandom_range(0, 5);
      for (i = 0; i <= len; i++) begin
        quiet = (n_sent + QuietTail >= RandItems);
        it.byte_first  = pick_byte();
        it.byte_second = pick_byte();
        it.byte_count  = 2'($urandom_range(0, 3));
        it.last_block  = (i == len);
        send_item(it);
        n_sent++;
      end
    end
    in_valid_i <= 1'b0;

    // drain, then leave room for any stray word
    @(posedge clk_i);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d blocks in %0d messages, %0d digest words checked",
             n_items, n_msgs, n_words);
    $display("tails of 0, 1, 2 and saturated bytes, stall bursts, long hold-off, drain pause");
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
